// ----- hw/rtl/wmeh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmeh_pkg
// Types and constants shared by the weight stabiliser: payload structs,
// controller states, command and status groups, fixed widths.
// ----------------------------------------------------------------------------
package wmeh_pkg;

   // sample format: signed Q16.8 grams
   localparam int SAMPLE_W = 24;
   // running average: signed Q16.16
   localparam int EMA_W    = SAMPLE_W + 8;
   // alpha * ema products
   localparam int PROD_W   = EMA_W + 10;
   // |ema| + half step, before dropping the 16 fraction bits
   localparam int NUM_W    = EMA_W + 2;
   // integer dividend fed to the step divider
   localparam int DIVD_W   = NUM_W - 16;
   localparam int DIVCNT_W = $clog2(DIVD_W + 1);

   localparam int ALPHA_W  = 9;
   localparam int STEP_W   = 10;
   localparam int HYST_W   = 10;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 10;

   localparam int SHOWN_W  = 15;
   localparam int ROUND_W  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_EMA_ALPHA    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_STEP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_HYST = 2'd2;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd51;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
   localparam logic [STEP_W-1:0]  STEP_RESET  = 10'd1;
   localparam logic [HYST_W-1:0]  HYST_RESET  = 10'd1;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_TARE   = 1'b1;

   localparam logic signed [ROUND_W-1:0] ROUND_MAX = 16'sh7FFF;
   localparam logic signed [ROUND_W-1:0] ROUND_MIN = 16'sh8000;

   typedef struct packed {
      logic                       req_type;
      logic signed [SAMPLE_W-1:0] raw_weight;
      logic                       raw_finite;
   } req_item_type;

   typedef struct packed {
      logic [SHOWN_W-1:0]        shown_weight;
      logic signed [ROUND_W-1:0] rounded_weight;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RANK,
      ST_MEDIAN,
      ST_EMA_MUL,
      ST_EMA_ADD,
      ST_ROUND,
      ST_DIV,
      ST_SCALE,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic rank;
      logic median;
      logic ema_mul;
      logic ema_add;
      logic div_start;
      logic scale;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rank_last;
      logic div_last;
      logic out_free;
   } dp_status_type;

endpackage

// ----- hw/rtl/weight_median_ema_hysteresis.sv -----
`timescale 1ns / 1ps
// A sample passes from acceptance through the rank scan (one entry a cycle), the median,
// the EMA, rounding, the bit-serial step divider, scaling and emit; a tare goes straight
// to emit. One transaction at a time: the next is taken the cycle after the result is
// loaded, even while that result still waits. Reset: synchronous, clears control state;
// window contents stay undefined until written.
// ----------------------------------------------------------------------------
// weight_median_ema_hysteresis
// Load-cell weight stabiliser: running median, EMA, step rounding and display
// hysteresis, split into a sequencer and a datapath.
// ----------------------------------------------------------------------------
module weight_median_ema_hysteresis #(
   parameter int WINDOW_SIZE = 5
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  wmeh_pkg::req_item_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output wmeh_pkg::rsp_item_type                rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [wmeh_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [wmeh_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   wmeh_pkg::ctrl_cmd_type  cmd;
   wmeh_pkg::dp_status_type status;

   wmeh_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_tare (req_data.req_type == wmeh_pkg::REQ_TARE),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   wmeh_dpath #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hw/rtl/wmeh_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmeh_div
// Restoring divider, one quotient bit per cycle, for the display step.
// ----------------------------------------------------------------------------
module wmeh_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [wmeh_pkg::DIVD_W-1:0]         dividend,
   input  logic [wmeh_pkg::STEP_W-1:0]         divisor,
   output logic [wmeh_pkg::DIVD_W-1:0]         quotient,
   output logic                                last
);

   logic                              busy_ff, busy_in;
   logic [wmeh_pkg::DIVCNT_W-1:0]     cnt_ff, cnt_in;
   logic [wmeh_pkg::DIVD_W-1:0]       quo_ff, quo_in;
   logic [wmeh_pkg::STEP_W-1:0]       rem_ff, rem_in;
   logic [wmeh_pkg::STEP_W-1:0]       dvs_ff, dvs_in;
   logic [wmeh_pkg::STEP_W:0]         shifted;
   logic [wmeh_pkg::STEP_W:0]         diff;
   logic                              ge;

   assign last     = busy_ff && (cnt_ff == wmeh_pkg::DIVCNT_W'(1));
   assign quotient = quo_ff;

   always_comb begin
      shifted = {rem_ff, quo_ff[wmeh_pkg::DIVD_W-1]};
      ge      = shifted >= {1'b0, dvs_ff};
      diff    = shifted - {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = wmeh_pkg::DIVCNT_W'(wmeh_pkg::DIVD_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - wmeh_pkg::DIVCNT_W'(1);
         quo_in = {quo_ff[wmeh_pkg::DIVD_W-2:0], ge};
         rem_in = ge ? diff[wmeh_pkg::STEP_W-1:0] : shifted[wmeh_pkg::STEP_W-1:0];
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

// ----- hw/rtl/wmeh_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmeh_dpath
// Sample window, rank-count median, EMA, step rounding, display hysteresis,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module wmeh_dpath #(
   parameter int WINDOW_SIZE = 5
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wmeh_pkg::ctrl_cmd_type                cmd,
   output wmeh_pkg::dp_status_type               status,
   input  wmeh_pkg::req_item_type                req_data,
   input  logic                                  csr_wr_en,
   input  logic [wmeh_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [wmeh_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output wmeh_pkg::rsp_item_type                rsp_data
);

   localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
   localparam int SW    = wmeh_pkg::SAMPLE_W;
   localparam int EW    = wmeh_pkg::EMA_W;
   localparam int PW    = wmeh_pkg::PROD_W;
   localparam int NW    = wmeh_pkg::NUM_W;
   localparam int DW    = wmeh_pkg::DIVD_W;
   localparam int RW    = wmeh_pkg::ROUND_W;
   localparam int WPW   = DW + wmeh_pkg::STEP_W;

   // configuration
   logic [wmeh_pkg::ALPHA_W-1:0] alpha_ff;
   logic [wmeh_pkg::STEP_W-1:0]  step_ff;
   logic [wmeh_pkg::HYST_W-1:0]  hyst_ff;

   // window and filter state
   logic signed [SW-1:0]  sample_ff [WINDOW_SIZE];
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic                  started_ff, started_in;
   logic signed [EW-1:0]  ema_ff, ema_in;
   logic signed [RW-1:0]  last_ff, last_in;
   logic                  tare_ff;

   // working registers
   logic [IDX_W-1:0]      cand_ff, cand_in;
   logic signed [SW-1:0]  lo_ff, lo_in;
   logic signed [SW-1:0]  hi_ff, hi_in;
   logic signed [SW-1:0]  med_ff, med_in;
   logic signed [PW-1:0]  pnew_ff, pnew_in;
   logic signed [PW-1:0]  pold_ff, pold_in;
   logic                  neg_ff;
   logic signed [RW-1:0]  w_ff, w_in;

   logic                  out_valid_ff, out_valid_in;
   wmeh_pkg::rsp_item_type out_data_ff, out_data_in;

   // combinational helpers
   logic signed [SW-1:0]  sample_in;
   logic signed [SW-1:0]  cand_val;
   logic [CNT_W-1:0]      less_cnt, leq_cnt;
   logic [CNT_W-1:0]      k_lo, k_hi;
   logic signed [SW:0]    med_sum;
   logic signed [EW-1:0]  med256;
   logic [wmeh_pkg::ALPHA_W-1:0] alpha_sat;
   logic [wmeh_pkg::ALPHA_W-1:0] alpha_inv;
   logic signed [PW-1:0]  ema_sum;
   logic [wmeh_pkg::STEP_W-1:0]  step_eff;
   logic [EW-1:0]         ema_mag;
   logic [NW-1:0]         num;
   logic [DW-1:0]         dividend;
   logic [DW-1:0]         quotient;
   logic                  div_last;
   logic [WPW-1:0]        w_mag;
   logic signed [RW:0]    hdiff;
   logic [RW:0]           hdiff_abs;
   logic                  out_take;

   wmeh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (step_eff),
      .quotient (quotient),
      .last     (div_last)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= wmeh_pkg::ALPHA_RESET;
         step_ff  <= wmeh_pkg::STEP_RESET;
         hyst_ff  <= wmeh_pkg::HYST_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            wmeh_pkg::CSR_EMA_ALPHA: begin
               alpha_ff <= csr_wdata[wmeh_pkg::ALPHA_W-1:0];
            end
            wmeh_pkg::CSR_DISPLAY_STEP: begin
               step_ff <= csr_wdata[wmeh_pkg::STEP_W-1:0];
            end
            wmeh_pkg::CSR_DISPLAY_HYST: begin
               hyst_ff <= csr_wdata[wmeh_pkg::HYST_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // window write and ring pointer
   assign sample_in = req_data.raw_finite ? req_data.raw_weight : '0;

   always_comb begin
      slot_in    = slot_ff;
      fill_in    = fill_ff;
      started_in = started_ff;
      if (cmd.load) begin
         if (req_data.req_type == wmeh_pkg::REQ_TARE) begin
            slot_in    = '0;
            fill_in    = '0;
            started_in = 1'b0;
         end else begin
            slot_in = (slot_ff == IDX_W'(WINDOW_SIZE - 1)) ? '0 : slot_ff + IDX_W'(1);
            if (fill_ff != CNT_W'(WINDOW_SIZE)) begin
               fill_in = fill_ff + CNT_W'(1);
            end
         end
      end else if (cmd.ema_add) begin
         started_in = 1'b1;
      end
   end

   // rank scan: one candidate per cycle, counted against every filled entry
   assign cand_val = sample_ff[cand_ff];
   assign k_lo     = (fill_ff - CNT_W'(1)) >> 1;
   assign k_hi     = fill_ff >> 1;

   always_comb begin
      less_cnt = '0;
      leq_cnt  = '0;
      for (int j = 0; j < WINDOW_SIZE; j++) begin
         if (CNT_W'(j) < fill_ff) begin
            less_cnt = less_cnt + CNT_W'(sample_ff[j] < cand_val);
            leq_cnt  = leq_cnt + CNT_W'(sample_ff[j] <= cand_val);
         end
      end
   end

   always_comb begin
      cand_in = cand_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      if (cmd.load) begin
         cand_in = '0;
      end else if (cmd.rank) begin
         cand_in = cand_ff + IDX_W'(1);
         if ((less_cnt <= k_lo) && (k_lo < leq_cnt)) begin
            lo_in = cand_val;
         end
         if ((less_cnt <= k_hi) && (k_hi < leq_cnt)) begin
            hi_in = cand_val;
         end
      end
   end

   // median: both middle entries equal for an odd count
   assign med_sum = {lo_ff[SW-1], lo_ff} + {hi_ff[SW-1], hi_ff};
   assign med_in  = cmd.median ? med_sum[SW:1] : med_ff;

   // EMA products, then sum and drop eight fraction bits
   assign med256    = {med_ff, 8'd0};
   assign alpha_sat = (alpha_ff > wmeh_pkg::ALPHA_ONE) ? wmeh_pkg::ALPHA_ONE : alpha_ff;
   assign alpha_inv = wmeh_pkg::ALPHA_ONE - alpha_sat;
   assign pnew_in   = $signed({1'b0, alpha_sat}) * med256;
   assign pold_in   = $signed({1'b0, alpha_inv}) * ema_ff;
   assign ema_sum   = pnew_ff + pold_ff;

   always_comb begin
      ema_in = ema_ff;
      if (cmd.ema_add) begin
         ema_in = started_ff ? ema_sum[EW+7:8] : med256;
      end
   end

   // rounding: q = floor((|ema| + step*2^15) / 2^16 / step)
   assign step_eff = (step_ff == '0) ? wmeh_pkg::STEP_W'(1) : step_ff;
   assign ema_mag  = ema_ff[EW-1] ? EW'(-ema_ff) : EW'(ema_ff);
   assign num      = NW'(ema_mag) + NW'({step_eff, 15'd0});
   assign dividend = num[NW-1:16];

   assign w_mag = WPW'(quotient) * WPW'(step_eff);

   always_comb begin
      w_in = w_ff;
      if (cmd.scale) begin
         if (neg_ff) begin
            if (w_mag > WPW'(32768)) begin
               w_in = wmeh_pkg::ROUND_MIN;
            end else begin
               w_in = RW'(-w_mag[RW-1:0]);
            end
         end else begin
            if (w_mag > WPW'(32767)) begin
               w_in = wmeh_pkg::ROUND_MAX;
            end else begin
               w_in = w_mag[RW-1:0];
            end
         end
      end
   end

   // display hysteresis and result register
   assign hdiff     = {w_ff[RW-1], w_ff} - {last_ff[RW-1], last_ff};
   assign hdiff_abs = hdiff[RW] ? (RW + 1)'(-hdiff) : (RW + 1)'(hdiff);
   assign out_take  = out_valid_ff && !rsp_stall;

   always_comb begin
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !out_take;
      out_data_in  = out_data_ff;
      if (cmd.load && (req_data.req_type == wmeh_pkg::REQ_TARE)) begin
         last_in = '0;
      end else if (cmd.emit) begin
         out_valid_in = 1'b1;
         if (tare_ff) begin
            out_data_in.shown_weight   = '0;
            out_data_in.rounded_weight = '0;
         end else begin
            if (hdiff_abs > (RW + 1)'(hyst_ff)) begin
               last_in = w_ff;
            end
            out_data_in.shown_weight   = last_in[RW-1] ? '0 : last_in[wmeh_pkg::SHOWN_W-1:0];
            out_data_in.rounded_weight = w_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         fill_ff      <= '0;
         started_ff   <= 1'b0;
         last_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         started_ff   <= started_in;
         last_ff      <= last_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && (req_data.req_type == wmeh_pkg::REQ_SAMPLE)) begin
         sample_ff[slot_ff] <= sample_in;
      end
      if (cmd.load) begin
         tare_ff <= (req_data.req_type == wmeh_pkg::REQ_TARE);
      end
      if (cmd.div_start) begin
         neg_ff <= ema_ff[EW-1];
      end
      cand_ff     <= cand_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      med_ff      <= med_in;
      if (cmd.ema_mul) begin
         pnew_ff <= pnew_in;
         pold_ff <= pold_in;
      end
      ema_ff      <= ema_in;
      w_ff        <= w_in;
      out_data_ff <= out_data_in;
   end

   assign status.rank_last = (CNT_W'(cand_ff) == fill_ff - CNT_W'(1));
   assign status.div_last  = div_last;
   assign status.out_free  = !out_valid_ff || !rsp_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ----- hw/rtl/wmeh_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmeh_ctrl
// Sequencer: steps one sample through rank scan, EMA, divide and emit; a tare goes straight to emit.
// ----------------------------------------------------------------------------
module wmeh_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_is_tare,
   output logic                      req_stall,
   input  wmeh_pkg::dp_status_type   status,
   output wmeh_pkg::ctrl_cmd_type    cmd
);

   wmeh_pkg::ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wmeh_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = req_is_tare ? wmeh_pkg::ST_EMIT : wmeh_pkg::ST_RANK;
            end
         end
         wmeh_pkg::ST_RANK: begin
            if (status.rank_last) begin
               state_in = wmeh_pkg::ST_MEDIAN;
            end
         end
         wmeh_pkg::ST_MEDIAN:  state_in = wmeh_pkg::ST_EMA_MUL;
         wmeh_pkg::ST_EMA_MUL: state_in = wmeh_pkg::ST_EMA_ADD;
         wmeh_pkg::ST_EMA_ADD: state_in = wmeh_pkg::ST_ROUND;
         wmeh_pkg::ST_ROUND:   state_in = wmeh_pkg::ST_DIV;
         wmeh_pkg::ST_DIV: begin
            if (status.div_last) begin
               state_in = wmeh_pkg::ST_SCALE;
            end
         end
         wmeh_pkg::ST_SCALE:   state_in = wmeh_pkg::ST_EMIT;
         wmeh_pkg::ST_EMIT: begin
            // hold until the result register can take the value
            if (status.out_free) begin
               state_in = wmeh_pkg::ST_IDLE;
            end
         end
         default:              state_in = wmeh_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         wmeh_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         wmeh_pkg::ST_RANK:    cmd.rank      = 1'b1;
         wmeh_pkg::ST_MEDIAN:  cmd.median    = 1'b1;
         wmeh_pkg::ST_EMA_MUL: cmd.ema_mul   = 1'b1;
         wmeh_pkg::ST_EMA_ADD: cmd.ema_add   = 1'b1;
         wmeh_pkg::ST_ROUND:   cmd.div_start = 1'b1;
         wmeh_pkg::ST_SCALE:   cmd.scale     = 1'b1;
         wmeh_pkg::ST_EMIT:    cmd.emit      = status.out_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wmeh_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- tb/tb_weight_median_ema_hysteresis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weight_median_ema_hysteresis
// Self-checking bench for the weight stabiliser. A clocked driver feeds sample
// and tare transactions from a backlog queue, and a clocked monitor compares
// every result with a cycle-free model of the median, EMA, step rounding and
// display hysteresis. Register settings change between phases, including the
// extremes. Both sides idle at random, and the receiver holds off once for a
// long stretch.
// ----------------------------------------------------------------------------
module tb_weight_median_ema_hysteresis;

   localparam int WIN_DEPTH     = 5;
   localparam int WATCHDOG_MAX  = 3000;
   localparam int CHOKE_AT      = 400;
   localparam int CHOKE_LEN     = 300;
   localparam int DRAIN_CYCLES  = 40;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 105;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   wmeh_pkg::req_item_type                req_data = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   wmeh_pkg::rsp_item_type                rsp_data;
   logic                                  csr_wr_en = 1'b0;
   logic [wmeh_pkg::CSR_IDX_W-1:0]        csr_index = wmeh_pkg::CSR_EMA_ALPHA;
   logic [wmeh_pkg::CSR_DATA_W-1:0]       csr_wdata = '0;

   // model state and register copies
   logic signed [wmeh_pkg::SAMPLE_W-1:0] ring [WIN_DEPTH];
   int                 slot = 0;
   int                 filled = 0;
   bit                 ema_live = 1'b0;
   longint             ema_q16 = 0;
   longint             shown_g = 0;
   logic [wmeh_pkg::ALPHA_W-1:0] alpha_reg = wmeh_pkg::ALPHA_RESET;
   logic [wmeh_pkg::STEP_W-1:0]  step_reg = wmeh_pkg::STEP_RESET;
   logic [wmeh_pkg::HYST_W-1:0]  hyst_reg = wmeh_pkg::HYST_RESET;

   wmeh_pkg::req_item_type backlog[$];
   wmeh_pkg::rsp_item_type due_weights[$];
   wmeh_pkg::rsp_item_type want;

   int queued_count = 0;
   int taken_count = 0;
   int tare_count = 0;
   int checked_count = 0;
   int error_count = 0;
   int phase_count = 0;
   int idle_cycles = 0;
   bit req_took = 1'b0;
   int gap_left = 0;
   int stall_left = 0;
   int choke_left = 0;
   bit choke_done = 1'b0;
   bit tx_quiet = 1'b0;
   bit rx_quiet = 1'b0;

   weight_median_ema_hysteresis #(.WINDOW_SIZE(WIN_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Advance the model by one transaction and return the display it should produce.
   function automatic wmeh_pkg::rsp_item_type settle_display(wmeh_pkg::req_item_type it);
      wmeh_pkg::rsp_item_type res;
      longint ord [WIN_DEPTH];
      longint key, med, span, mag, q, w, move_g;
      int j, alpha, step;
      res = '0;
      if (it.req_type == wmeh_pkg::REQ_TARE) begin
         slot = 0;
         filled = 0;
         ema_live = 1'b0;
         shown_g = 0;
         return res;
      end
      ring[slot] = it.raw_finite ? it.raw_weight : '0;
      slot = (slot + 1) % WIN_DEPTH;
      if (filled < WIN_DEPTH) filled++;
      for (int i = 0; i < filled; i++) begin
         key = longint'(ring[i]);
         j = i;
         while (j > 0 && ord[j-1] > key) begin
            ord[j] = ord[j-1];
            j--;
         end
         ord[j] = key;
      end
      if (filled % 2 == 0) med = (ord[filled/2 - 1] + ord[filled/2]) >>> 1;
      else med = ord[filled/2];

      alpha = (alpha_reg > wmeh_pkg::ALPHA_ONE) ? int'(wmeh_pkg::ALPHA_ONE) : int'(alpha_reg);
      if (!ema_live) begin
         ema_q16 = med * 256;
         ema_live = 1'b1;
      end else begin
         ema_q16 = (longint'(alpha) * med * 256 + longint'(256 - alpha) * ema_q16) >>> 8;
      end

      // round half away from zero to a whole number of steps
      step = (step_reg == '0) ? 1 : int'(step_reg);
      span = longint'(step) * 65536;
      mag = (ema_q16 < 0) ? -ema_q16 : ema_q16;
      q = (mag + span / 2) / span;
      w = q * step;
      if (ema_q16 < 0) w = -w;
      if (w > longint'(wmeh_pkg::ROUND_MAX)) w = longint'(wmeh_pkg::ROUND_MAX);
      if (w < longint'(wmeh_pkg::ROUND_MIN)) w = longint'(wmeh_pkg::ROUND_MIN);

      move_g = w - shown_g;
      if (move_g < 0) move_g = -move_g;
      if (move_g > longint'(hyst_reg)) shown_g = w;

      res.shown_weight = (shown_g < 0) ? '0 : wmeh_pkg::SHOWN_W'(shown_g);
      res.rounded_weight = wmeh_pkg::ROUND_W'(w);
      return res;
   endfunction

   function automatic int pause_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   task automatic offer_reading(longint q8, bit finite);
      wmeh_pkg::req_item_type it;
      if (q8 > 8388607) q8 = 8388607;
      if (q8 < -8388608) q8 = -8388608;
      it.req_type = wmeh_pkg::REQ_SAMPLE;
      it.raw_weight = wmeh_pkg::SAMPLE_W'(q8);
      it.raw_finite = finite;
      backlog.push_back(it);
      queued_count++;
   endtask

   task automatic offer_tare();
      wmeh_pkg::req_item_type it;
      it.req_type = wmeh_pkg::REQ_TARE;
      it.raw_weight = wmeh_pkg::SAMPLE_W'($urandom());
      it.raw_finite = 1'($urandom_range(0, 1));
      backlog.push_back(it);
      queued_count++;
   endtask

   // Every transaction yields one result, so the block is idle once all are checked.
   task automatic wait_idle();
      while (checked_count < queued_count) @(negedge clock);
   endtask

   // Call at a falling edge with the block idle.
   task automatic program_regs(int alpha, int step, int hyst);
      csr_wr_en <= 1'b1;
      csr_index <= wmeh_pkg::CSR_EMA_ALPHA;
      csr_wdata <= wmeh_pkg::CSR_DATA_W'(alpha);
      alpha_reg = wmeh_pkg::ALPHA_W'(alpha);
      @(negedge clock);
      csr_index <= wmeh_pkg::CSR_DISPLAY_STEP;
      csr_wdata <= wmeh_pkg::CSR_DATA_W'(step);
      step_reg = wmeh_pkg::STEP_W'(step);
      @(negedge clock);
      csr_index <= wmeh_pkg::CSR_DISPLAY_HYST;
      csr_wdata <= wmeh_pkg::CSR_DATA_W'(hyst);
      hyst_reg = wmeh_pkg::HYST_W'(hyst);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      phase_count++;
   endtask

   // driver: offer the next transaction once the current one has gone
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_took) begin
         // hold the stalled transaction
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left--;
      end else if (backlog.size() != 0) begin
         req_data <= backlog.pop_front();
         req_valid <= 1'b1;
         gap_left = tx_quiet ? 0 : pause_len();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver back-pressure, with one long hold-off part way through
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (choke_left > 0) begin
         rsp_stall <= 1'b1;
         choke_left--;
      end else if (!choke_done && checked_count >= CHOKE_AT) begin
         choke_done = 1'b1;
         choke_left = CHOKE_LEN - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (rx_quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_left = pause_len();
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // monitor: check results first, then record the accepted request
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         checked_count++;
         if (due_weights.size() == 0) begin
            error_count++;
            $error("unexpected result: shown_weight %0d, rounded_weight %0d",
                   rsp_data.shown_weight, $signed(rsp_data.rounded_weight));
         end else begin
            want = due_weights.pop_front();
            if (rsp_data.shown_weight !== want.shown_weight) begin
               error_count++;
               $error("shown_weight: expected %0d, actual %0d",
                      want.shown_weight, rsp_data.shown_weight);
            end
            if (rsp_data.rounded_weight !== want.rounded_weight) begin
               error_count++;
               $error("rounded_weight: expected %0d, actual %0d",
                      $signed(want.rounded_weight), $signed(rsp_data.rounded_weight));
            end
         end
      end
      req_took = !reset && req_valid && !req_stall;
      if (req_took) begin
         due_weights.push_back(settle_display(req_data));
         taken_count++;
         if (req_data.req_type == wmeh_pkg::REQ_TARE) tare_count++;
      end
      if (req_took || (!reset && rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
   end

   initial begin : watchdog
      wait (idle_cycles >= WATCHDOG_MAX);
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_MAX);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int base_g, spread, pick, alpha, step, hyst;
      logic signed [wmeh_pkg::SAMPLE_W-1:0] wild;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // reset settings: extremes, forced zero, odd and even fills, window wrap
      offer_reading(8388607, 1'b1);
      offer_reading(-8388608, 1'b1);
      offer_reading(12345, 1'b0);
      offer_reading(-1, 1'b1);
      offer_reading(1, 1'b1);
      offer_reading(7 * 256, 1'b1);
      offer_reading(-384, 1'b1);
      // half a gram either side of zero rounds away from zero
      offer_tare();
      offer_reading(128, 1'b1);
      offer_tare();
      offer_reading(-128, 1'b1);
      wait_idle();

      // full alpha, zero step and zero hysteresis
      program_regs(int'(wmeh_pkg::ALPHA_ONE), 0, 0);
      offer_tare();
      offer_reading(-384, 1'b1);
      offer_reading(1280, 1'b1);
      offer_reading(-1281, 1'b1);
      wait_idle();

      // frozen EMA, saturation of the rounded value both ways
      program_regs(0, 1000, 1000);
      offer_tare();
      offer_reading(-8388608, 1'b1);
      offer_tare();
      offer_reading(8388607, 1'b1);
      offer_reading(-8388608, 1'b1);
      wait_idle();

      // alpha above one, step and hysteresis beyond their nominal range
      program_regs(511, 1023, 1023);
      offer_tare();
      offer_reading(524 * 256, 1'b1);
      offer_reading(-524 * 256, 1'b1);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         case ($urandom_range(0, 5))
            0: alpha = 0;
            1: alpha = 1;
            2: alpha = int'(wmeh_pkg::ALPHA_ONE);
            3: alpha = 511;
            default: alpha = $urandom_range(1, 256);
         endcase
         case ($urandom_range(0, 5))
            0: step = 0;
            1: step = 1;
            2: step = 1000;
            3: step = 1023;
            default: step = $urandom_range(1, 20);
         endcase
         case ($urandom_range(0, 5))
            0: hyst = 0;
            1: hyst = 1000;
            2: hyst = 1023;
            default: hyst = $urandom_range(0, 30);
         endcase
         program_regs(alpha, step, hyst);
         tx_quiet = (p % 4 == 3);
         rx_quiet = (p % 5 == 2);
         case ($urandom_range(0, 3))
            0: spread = 0;
            1: spread = 64;
            2: spread = 2560;
            default: spread = 25600;
         endcase
         base_g = int'($urandom_range(0, 36000)) - 2000;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // occasionally the load on the scale changes
            if ($urandom_range(0, 29) == 0) base_g = int'($urandom_range(0, 36000)) - 2000;
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
               offer_tare();
            end else if (pick < 14) begin
               wild = wmeh_pkg::SAMPLE_W'($urandom());
               offer_reading(longint'(wild), 1'($urandom_range(0, 1)));
            end else begin
               offer_reading(longint'(base_g) * 256 + int'($urandom_range(0, 2 * spread))
                             - spread, $urandom_range(0, 19) != 0);
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Checked %0d results for %0d transactions (%0d tares) over %0d settings.",
               checked_count, taken_count, tare_count, phase_count + 1);
      $display("Both sides idled at random; the receiver held off once for %0d cycles.",
               CHOKE_LEN);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
